// ----- rtl/core/bfs_pkg.sv -----
// bfs_pkg: shared constants, codes and controller/datapath interface types
// for the shortest path engine; no dependencies
`default_nettype none
package bfs_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VID_W        = $clog2(MAX_VERTICES);
    localparam int SLOTS        = MAX_VERTICES + 1;
    localparam int ADDR_W       = $clog2(MAX_VERTICES * SLOTS);
    localparam int DEG_W        = $clog2(SLOTS + 1);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CFG_W        = 6;

    // input kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_PATH    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_NOCONN  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DISPATCH = 12'b0000_0000_0010,
        S_SCAN_RD  = 12'b0000_0000_0100,
        S_SCAN_CHK = 12'b0000_0000_1000,
        S_WR_A     = 12'b0000_0001_0000,
        S_WR_B     = 12'b0000_0010_0000,
        S_POP      = 12'b0000_0100_0000,
        S_NB_RD    = 12'b0000_1000_0000,
        S_NB_CHK   = 12'b0001_0000_0000,
        S_TRACE    = 12'b0010_0000_0000,
        S_EMIT     = 12'b0100_0000_0000,
        S_RESP     = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic       latch_in;
        logic       clear_graph;
        logic       set_blocked;
        logic       clr_blocked;
        logic       scan_init;
        logic       rd_issue;
        logic       scan_next;
        logic       wr_a;
        logic       wr_b;
        logic       bfs_init;
        logic       pop;
        logic       nb_check;
        logic       trace_step;
        logic       emit_init;
        logic       emit_path;
        logic       emit_status;
        logic [1:0] resp_code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       blocked;
        logic       range_bad;
        logic       same_ab;
        logic       scan_done;
        logic       scan_hit;
        logic       queue_empty;
        logic       nb_new;
        logic       nb_dst;
        logic       trace_done;
        logic       emit_last;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/bfs_shortest_path_engine.sv -----
// bfs_shortest_path_engine: top level, joins sequencer and datapath
// depends on bfs_pkg, bfs_ctrl, bfs_dpath
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------
//  s_ input  | in  | s_tvalid/s_tready  | s_tdata: vertex_a, vertex_b; s_tuser: kind
//  m_ result | out | m_tvalid/m_tready  | m_tdata: path_vertex, status; m_tlast: last
//  cfg       | in  | cfg_wr_en          | cfg_wr_data: vertex_count
//
// one item at a time; clear and status answers pass dispatch and the response
// state to the result register; an edge insert reads and checks each entry
// already in the first end's list, then writes both lists; a query dispatches,
// then reads and checks each neighbour entry of each dequeued vertex from the
// single-port neighbour memory, then traces and emits each path vertex
// reset is synchronous and needs no clearing pass; a stalled m_ side holds the
// sequencer, and the next item is taken while the last result waits
`default_nettype none
module bfs_shortest_path_engine (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire  [15:0]                s_tdata,   // [4:0] vertex_a, [9:5] vertex_b
    input  wire  [1:0]                 s_tuser,   // [1:0] kind
    output logic                       m_tvalid,
    input  wire                        m_tready,
    output logic [7:0]                 m_tdata,   // [4:0] path_vertex, [6:5] status
    output logic                       m_tlast,
    input  wire                        cfg_wr_en,
    input  wire  [bfs_pkg::CFG_W-1:0]  cfg_wr_data
);

    bfs_pkg::cmd_t              cmd;
    bfs_pkg::sts_t              sts;
    logic [bfs_pkg::VID_W-1:0]  out_vertex;
    logic [1:0]                 out_status;

    bfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfs_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_a        (s_tdata[4:0]),
        .in_b        (s_tdata[9:5]),
        .in_kind     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_vertex  (out_vertex),
        .out_status  (out_status),
        .out_last    (m_tlast)
    );

    // pack result transaction
    assign m_tdata = {1'b0, out_status, out_vertex};

endmodule
`default_nettype wire

// ----- rtl/core/bfs_ctrl.sv -----
// bfs_ctrl: sequencer for clear, edge insert and breadth-first query
// depends on bfs_pkg
`default_nettype none
module bfs_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  bfs_pkg::sts_t       sts,
    output bfs_pkg::cmd_t       cmd
);

    bfs_pkg::state_t state_reg, state_next;
    logic [1:0]      code_reg, code_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfs_pkg::S_IDLE;
            code_reg  <= bfs_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign s_tready = (state_reg == bfs_pkg::S_IDLE);

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        cmd           = '0;
        cmd.resp_code = code_reg;
        unique case (state_reg)
            bfs_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = bfs_pkg::S_DISPATCH;
                end
            end
            bfs_pkg::S_DISPATCH: begin
                state_next = bfs_pkg::S_RESP;
                code_next  = bfs_pkg::ST_INVALID;
                case (sts.kind)
                    bfs_pkg::KIND_CLEAR: begin
                        cmd.clear_graph = 1'b1;
                        cmd.clr_blocked = 1'b1;
                        code_next       = bfs_pkg::ST_OK;
                    end
                    bfs_pkg::KIND_EDGE: begin
                        if (!sts.blocked && sts.range_bad) begin
                            cmd.clear_graph = 1'b1;
                            cmd.set_blocked = 1'b1;
                        end else if (!sts.blocked) begin
                            cmd.scan_init = 1'b1;
                            state_next    = bfs_pkg::S_SCAN_RD;
                        end
                    end
                    bfs_pkg::KIND_QUERY: begin
                        if (!sts.blocked && !sts.range_bad) begin
                            if (sts.same_ab) begin
                                code_next = bfs_pkg::ST_NOCONN;
                            end else begin
                                cmd.bfs_init = 1'b1;
                                state_next   = bfs_pkg::S_POP;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // duplicate edge search over the first end's list
            bfs_pkg::S_SCAN_RD: begin
                if (sts.scan_done) begin
                    state_next = bfs_pkg::S_WR_A;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = bfs_pkg::S_SCAN_CHK;
                end
            end
            bfs_pkg::S_SCAN_CHK: begin
                if (sts.scan_hit) begin
                    cmd.clear_graph = 1'b1;
                    cmd.set_blocked = 1'b1;
                    code_next       = bfs_pkg::ST_INVALID;
                    state_next      = bfs_pkg::S_RESP;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = bfs_pkg::S_SCAN_RD;
                end
            end
            // a list can never overflow with distinct edges, so no full check
            bfs_pkg::S_WR_A: begin
                cmd.wr_a   = 1'b1;
                state_next = bfs_pkg::S_WR_B;
            end
            bfs_pkg::S_WR_B: begin
                cmd.wr_b   = 1'b1;
                code_next  = bfs_pkg::ST_OK;
                state_next = bfs_pkg::S_RESP;
            end
            // breadth-first search
            bfs_pkg::S_POP: begin
                if (sts.queue_empty) begin
                    code_next  = bfs_pkg::ST_NOCONN;
                    state_next = bfs_pkg::S_RESP;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = bfs_pkg::S_NB_RD;
                end
            end
            bfs_pkg::S_NB_RD: begin
                if (sts.scan_done) begin
                    state_next = bfs_pkg::S_POP;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = bfs_pkg::S_NB_CHK;
                end
            end
            bfs_pkg::S_NB_CHK: begin
                cmd.nb_check  = 1'b1;
                cmd.scan_next = 1'b1;
                if (sts.nb_new && sts.nb_dst) begin
                    state_next = bfs_pkg::S_TRACE;
                end else begin
                    state_next = bfs_pkg::S_NB_RD;
                end
            end
            // walk predecessors back to the source
            bfs_pkg::S_TRACE: begin
                if (sts.trace_done) begin
                    cmd.emit_init = 1'b1;
                    state_next    = bfs_pkg::S_EMIT;
                end else begin
                    cmd.trace_step = 1'b1;
                end
            end
            bfs_pkg::S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_path = 1'b1;
                    if (sts.emit_last) begin
                        state_next = bfs_pkg::S_IDLE;
                    end
                end
            end
            bfs_pkg::S_RESP: begin
                if (sts.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = bfs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bfs_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/bfs_dpath.sv -----
// bfs_dpath: neighbour memory, degree counters, search queue, trail and
// output register; depends on bfs_pkg
`default_nettype none
module bfs_dpath (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire  [bfs_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire  [bfs_pkg::VID_W-1:0]    in_a,
    input  wire  [bfs_pkg::VID_W-1:0]    in_b,
    input  wire  [1:0]                   in_kind,
    input  bfs_pkg::cmd_t                cmd,
    output bfs_pkg::sts_t                sts,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [bfs_pkg::VID_W-1:0]    out_vertex,
    output logic [1:0]                   out_status,
    output logic                         out_last
);

    localparam int VW = bfs_pkg::VID_W;
    localparam int NV = bfs_pkg::MAX_VERTICES;

    logic [bfs_pkg::CFG_W-1:0]  vcount_reg;
    logic [1:0]                 kind_reg;
    logic [VW-1:0]              a_reg, b_reg, v_reg, c_reg, idx_reg;
    logic [bfs_pkg::DEG_W-1:0]  i_reg;
    logic [bfs_pkg::DEG_W-1:0]  deg_reg [NV];
    logic                       blocked_reg;
    logic [NV-1:0]              visited_reg;
    logic [VW-1:0]              pred_reg  [NV];
    logic [VW-1:0]              queue_reg [NV];
    logic [VW-1:0]              trail_reg [NV];
    logic [bfs_pkg::CNT_W-1:0]  head_reg, tail_reg, len_reg;
    logic [VW-1:0]              mem_array [NV * bfs_pkg::SLOTS];
    logic [VW-1:0]              rdata_reg;
    logic                       out_valid_reg;
    logic [VW-1:0]              out_vertex_reg;
    logic [1:0]                 out_status_reg;
    logic                       out_last_reg;

    logic [bfs_pkg::CFG_W-1:0]  live_n;
    logic [VW-1:0]              base_v, deg_addr;
    logic [bfs_pkg::DEG_W-1:0]  deg_rd, mem_off;
    logic [bfs_pkg::ADDR_W-1:0] mem_addr;
    logic                       out_free;

    // live vertex count, capped at the table size
    assign live_n = (vcount_reg > bfs_pkg::CFG_W'(NV)) ? bfs_pkg::CFG_W'(NV) : vcount_reg;

    // one degree read port and one memory address
    assign deg_addr = cmd.wr_b ? b_reg : v_reg;
    assign base_v   = deg_addr;
    assign deg_rd   = deg_reg[deg_addr];
    assign mem_off  = cmd.rd_issue ? i_reg : deg_rd;
    assign mem_addr = bfs_pkg::ADDR_W'({base_v, {VW{1'b0}}})
                    + bfs_pkg::ADDR_W'(base_v) + bfs_pkg::ADDR_W'(mem_off);

    assign out_free = !out_valid_reg || out_ready;

    // status to the controller
    always_comb begin
        sts             = '0;
        sts.kind        = kind_reg;
        sts.blocked     = blocked_reg;
        sts.range_bad   = ({1'b0, a_reg} >= live_n) || ({1'b0, b_reg} >= live_n);
        sts.same_ab     = (a_reg == b_reg);
        sts.scan_done   = (i_reg == deg_rd);
        sts.scan_hit    = (rdata_reg == b_reg);
        sts.queue_empty = (head_reg == tail_reg);
        sts.nb_new      = !visited_reg[rdata_reg];
        sts.nb_dst      = (rdata_reg == b_reg);
        sts.trace_done  = (c_reg == a_reg) || (len_reg == bfs_pkg::CNT_W'(NV));
        sts.emit_last   = (idx_reg == '0);
        sts.out_free    = out_free;
    end

    // neighbour memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_array[mem_addr] <= b_reg;
        end else if (cmd.wr_b) begin
            mem_array[mem_addr] <= a_reg;
        end
        if (cmd.rd_issue) begin
            rdata_reg <= mem_array[mem_addr];
        end
    end

    // control state: config, block flag, degrees, marks, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg    <= '0;
            blocked_reg   <= 1'b0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NV; k++) begin
                deg_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
            if (cmd.set_blocked) begin
                blocked_reg <= 1'b1;
            end else if (cmd.clr_blocked) begin
                blocked_reg <= 1'b0;
            end
            if (cmd.clear_graph) begin
                for (int k = 0; k < NV; k++) begin
                    deg_reg[k] <= '0;
                end
            end else if (cmd.wr_a || cmd.wr_b) begin
                deg_reg[deg_addr] <= deg_rd + 1'b1;
            end
            // only the source is marked at the start of a search
            if (cmd.bfs_init) begin
                visited_reg <= NV'(1) << a_reg;
            end else if (cmd.nb_check && !visited_reg[rdata_reg]) begin
                visited_reg[rdata_reg] <= 1'b1;
            end
            if (cmd.emit_path || cmd.emit_status) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // search counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            len_reg  <= '0;
            i_reg    <= '0;
        end else begin
            if (cmd.scan_init || cmd.pop) begin
                i_reg <= '0;
            end else if (cmd.scan_next) begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.bfs_init) begin
                head_reg <= '0;
                tail_reg <= bfs_pkg::CNT_W'(1);
            end else begin
                if (cmd.pop) begin
                    head_reg <= head_reg + 1'b1;
                end
                if (cmd.nb_check && !visited_reg[rdata_reg]
                    && tail_reg < bfs_pkg::CNT_W'(NV)) begin
                    tail_reg <= tail_reg + 1'b1;
                end
            end
            if (cmd.nb_check && !visited_reg[rdata_reg] && rdata_reg == b_reg) begin
                len_reg <= bfs_pkg::CNT_W'(1);
            end else if (cmd.trace_step) begin
                len_reg <= len_reg + 1'b1;
            end
        end
    end

    // payload: latched item, queue, predecessors, trail, result
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            kind_reg <= in_kind;
            a_reg    <= in_a;
            b_reg    <= in_b;
        end
        if (cmd.scan_init) begin
            v_reg <= a_reg;
        end else if (cmd.pop) begin
            v_reg <= queue_reg[head_reg[VW-1:0]];
        end
        if (cmd.bfs_init) begin
            queue_reg[0] <= a_reg;
        end
        if (cmd.nb_check && !visited_reg[rdata_reg]) begin
            pred_reg[rdata_reg] <= v_reg;
            if (tail_reg < bfs_pkg::CNT_W'(NV)) begin
                queue_reg[tail_reg[VW-1:0]] <= rdata_reg;
            end
            if (rdata_reg == b_reg) begin
                c_reg        <= b_reg;
                trail_reg[0] <= b_reg;
            end
        end
        if (cmd.trace_step) begin
            c_reg                      <= pred_reg[c_reg];
            trail_reg[len_reg[VW-1:0]] <= pred_reg[c_reg];
        end
        if (cmd.emit_init) begin
            idx_reg <= VW'(len_reg - 1'b1);
        end else if (cmd.emit_path) begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.emit_path) begin
            out_vertex_reg <= trail_reg[idx_reg];
            out_status_reg <= bfs_pkg::ST_PATH;
            out_last_reg   <= (idx_reg == '0);
        end else if (cmd.emit_status) begin
            out_vertex_reg <= '0;
            out_status_reg <= cmd.resp_code;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_vertex = out_vertex_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

// ----- rtl/core/bfs_checker.sv -----
// bfs_checker: port-level assertions for the shortest path engine, bound to
// the top level; depends on bfs_shortest_path_engine ports only
`default_nettype none
module bfs_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_tvalid,
    input wire       s_tready,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tlast
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // nothing pending straight after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // status-only results are single and carry vertex zero
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6:5] != 2'd0 |-> m_tlast && m_tdata[4:0] == 5'd0)
        else $error("status result malformed");

    // an input transaction is never taken in the cycle after another one
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

endmodule

bind bfs_shortest_path_engine bfs_checker u_bfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- dv/bfs_shortest_path_engine_tb.sv -----
// bfs_shortest_path_engine_tb: self-checking bench for the shortest path engine
// drives edge, clear and query transactions, predicts every path in-bench
// depends on bfs_pkg and bfs_shortest_path_engine
`timescale 1ns / 1ps
module bfs_shortest_path_engine_tb;

    localparam int NV = bfs_pkg::MAX_VERTICES;
    localparam int NSLOT = NV + 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int OP_DEPTH = 1024;
    localparam int EXP_DEPTH = 8192;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] va;
        logic [4:0] vb;
    } graph_op_t;

    typedef struct packed {
        logic [4:0] vtx;
        logic [1:0] st;
        logic       lst;
    } path_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic [bfs_pkg::CFG_W-1:0] cfg_wr_data = '0;

    // pending items and expected results, kept as ring buffers
    graph_op_t op_mem [OP_DEPTH];
    int op_wr = 0;
    int op_rd = 0;
    path_word_t exp_mem [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    int error_count = 0;
    bit quiet_phase = 1'b0;
    int watchdog = 0;
    int src_gap = 0;
    int snk_gap = 0;

    // predictor state
    logic [4:0] adj_list [NV*NSLOT];
    int adj_deg [NV];
    bit graph_locked;
    int live_n;

    bfs_shortest_path_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic void expect_word(path_word_t w);
        exp_mem[exp_wr % EXP_DEPTH] = w;
        exp_wr++;
    endfunction

    function automatic void push_status(logic [1:0] st);
        expect_word('{vtx: 5'd0, st: st, lst: 1'b1});
    endfunction

    // shortest path search in neighbour-list order, early stop at destination
    function automatic void predict_path(int src, int dst);
        bit seen [NV];
        int pred [NV];
        int fifo [NV];
        int trail [NV];
        int head, tail, len, u, w, c;
        bit found;
        head = 0; tail = 0; found = 0; len = 0;
        foreach (seen[i]) begin
            seen[i] = 0;
            pred[i] = 0;
        end
        seen[src] = 1;
        fifo[tail++] = src;
        while (head < tail && !found) begin
            u = fifo[head++];
            for (int i = 0; i < adj_deg[u]; i++) begin
                w = adj_list[u*NSLOT+i];
                if (!seen[w]) begin
                    seen[w] = 1;
                    pred[w] = u;
                    if (tail < NV) fifo[tail++] = w;
                    if (w == dst) begin
                        found = 1;
                        break;
                    end
                end
            end
        end
        if (!found) begin
            push_status(bfs_pkg::ST_NOCONN);
            return;
        end
        c = dst;
        trail[len++] = c;
        while (c != src && len < NV) begin
            c = pred[c];
            trail[len++] = c;
        end
        for (int i = 0; i < len; i++)
            expect_word('{vtx: trail[len-1-i][4:0], st: bfs_pkg::ST_PATH,
                          lst: (i + 1 == len)});
    endfunction

    function automatic void predict_op(graph_op_t op);
        int a, b;
        bit bad;
        a = op.va;
        b = op.vb;
        if (op.kind == bfs_pkg::KIND_CLEAR) begin
            foreach (adj_deg[i]) adj_deg[i] = 0;
            graph_locked = 0;
            push_status(bfs_pkg::ST_OK);
        end else if (op.kind == bfs_pkg::KIND_EDGE) begin
            if (graph_locked) begin
                push_status(bfs_pkg::ST_INVALID);
                return;
            end
            bad = (a >= live_n) || (b >= live_n);
            if (!bad)
                for (int i = 0; i < adj_deg[a]; i++)
                    if (adj_list[a*NSLOT+i] == b) bad = 1;
            if (!bad)
                bad = (a == b) ? (adj_deg[a] + 2 > NSLOT)
                               : (adj_deg[a] >= NSLOT || adj_deg[b] >= NSLOT);
            if (bad) begin
                foreach (adj_deg[i]) adj_deg[i] = 0;
                graph_locked = 1;
                push_status(bfs_pkg::ST_INVALID);
                return;
            end
            adj_list[a*NSLOT+adj_deg[a]] = b[4:0];
            adj_deg[a]++;
            adj_list[b*NSLOT+adj_deg[b]] = a[4:0];
            adj_deg[b]++;
            push_status(bfs_pkg::ST_OK);
        end else if (op.kind == bfs_pkg::KIND_QUERY) begin
            if (graph_locked || a >= live_n || b >= live_n)
                push_status(bfs_pkg::ST_INVALID);
            else if (a == b) push_status(bfs_pkg::ST_NOCONN);
            else predict_path(a, b);
        end else begin
            push_status(bfs_pkg::ST_INVALID);
        end
    endfunction

    // driver: one transaction per handshake, random idle bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_op(op_mem[op_rd % OP_DEPTH]);
                op_rd = op_rd + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (op_wr > op_rd) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, op_mem[op_rd % OP_DEPTH].vb,
                                op_mem[op_rd % OP_DEPTH].va};
                    s_tuser <= op_mem[op_rd % OP_DEPTH].kind;
                    if (!quiet_phase && $urandom_range(0, 5) == 0)
                        src_gap <= $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink backpressure
    always @(posedge aclk) begin
        path_word_t got, exp_w;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (m_tvalid && m_tready) begin
                got = '{vtx: m_tdata[4:0], st: m_tdata[6:5], lst: m_tlast};
                if (exp_rd == exp_wr) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    error_count++;
                end else begin
                    exp_w = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd = exp_rd + 1;
                    if (got.vtx !== exp_w.vtx) begin
                        $display("%0t: path_vertex expected %0d actual %0d",
                                 $time, exp_w.vtx, got.vtx);
                        error_count++;
                    end
                    if (got.st !== exp_w.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, exp_w.st, got.st);
                        error_count++;
                    end
                    if (got.lst !== exp_w.lst) begin
                        $display("%0t: last expected %0d actual %0d", $time, exp_w.lst, got.lst);
                        error_count++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
                snk_gap <= $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic add_op(logic [1:0] k, int a, int b);
        op_mem[op_wr % OP_DEPTH] = '{kind: k, va: a[4:0], vb: b[4:0]};
        op_wr++;
    endtask

    task automatic drain();
        wait (op_rd == op_wr && !s_tvalid);
        wait (exp_rd == exp_wr);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_count(int n);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n[bfs_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        live_n = (n > NV) ? NV : n;
    endtask

    // a burst: clear, a random graph that may hold duplicate edges, then queries
    task automatic random_graph(int n, int edges, int queries);
        add_op(bfs_pkg::KIND_CLEAR, $urandom, $urandom);
        for (int i = 0; i < edges; i++)
            add_op(bfs_pkg::KIND_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
        for (int i = 0; i < queries; i++)
            add_op(bfs_pkg::KIND_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
    endtask

    initial begin
        int n;
        foreach (adj_deg[i]) adj_deg[i] = 0;
        graph_locked = 0;
        live_n = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero vertices: everything out of range
        add_op(bfs_pkg::KIND_EDGE, 0, 0);
        add_op(bfs_pkg::KIND_CLEAR, 0, 0);
        add_op(bfs_pkg::KIND_QUERY, 0, 0);
        drain();

        // full size chain 0..31 and extremes
        set_count(32);
        add_op(bfs_pkg::KIND_CLEAR, 31, 31);
        for (int i = 0; i < 31; i++) add_op(bfs_pkg::KIND_EDGE, i, i + 1);
        add_op(bfs_pkg::KIND_QUERY, 0, 31);
        add_op(bfs_pkg::KIND_QUERY, 31, 0);
        add_op(bfs_pkg::KIND_QUERY, 5, 5);
        add_op(KIND_RESERVED, 31, 31);
        drain();

        // self loop, duplicate edge, blocked graph, shrunken count
        set_count(63);
        add_op(bfs_pkg::KIND_CLEAR, 0, 0);
        add_op(bfs_pkg::KIND_EDGE, 3, 3);
        add_op(bfs_pkg::KIND_EDGE, 3, 9);
        add_op(bfs_pkg::KIND_EDGE, 9, 20);
        add_op(bfs_pkg::KIND_QUERY, 3, 20);
        drain();
        set_count(10);
        add_op(bfs_pkg::KIND_QUERY, 3, 9);
        add_op(bfs_pkg::KIND_QUERY, 3, 12);
        add_op(bfs_pkg::KIND_EDGE, 9, 3);
        add_op(bfs_pkg::KIND_QUERY, 3, 9);
        add_op(bfs_pkg::KIND_EDGE, 1, 2);
        add_op(bfs_pkg::KIND_CLEAR, 0, 0);
        add_op(bfs_pkg::KIND_QUERY, 1, 2);
        drain();

        // random phases at different sizes; the sender holds off between them
        for (int p = 0; p < 8; p++) begin
            n = (p == 0) ? 2 : (p == 7) ? 32 : $urandom_range(3, 16);
            set_count((p == 5) ? 40 + $urandom_range(0, 23) : n);
            if (p == 5) n = 32;
            random_graph(n, $urandom_range(2, n), 6);
            if ($urandom_range(0, 3) == 0)
                add_op($urandom, $urandom, $urandom);
            if (p == 6) quiet_phase = 1'b1;
            drain();
        end

        wait (exp_rd == exp_wr);
        repeat (80) @(posedge aclk);
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/bfs_pkg.sv
rtl/core/bfs_ctrl.sv
rtl/core/bfs_dpath.sv
rtl/core/bfs_shortest_path_engine.sv
rtl/core/bfs_checker.sv
dv/bfs_shortest_path_engine_tb.sv
